// ===== sv/eht_pkg.sv =====
// Shared types, constants and arithmetic helpers for the equatorial/horizontal
// coordinate transform. No dependencies; every other file imports this package.
package eht_pkg;

    // Angle formats: external angles are ANGLE_BITS wide, internal ones are 32 bits.
    localparam int ANGLE_BITS   = 24;
    localparam int INT_BITS     = 32;
    localparam int ANGLE_SHIFT  = INT_BITS - ANGLE_BITS;
    localparam int CORDIC_STEPS = 30;
    // Datapath width for CORDIC vectors and Q30 products.
    localparam int DW           = 34;

    localparam logic signed [DW-1:0] KINV = DW'(64'sd652032874);
    localparam logic [INT_BITS-1:0] HALF_TURN = 32'h8000_0000;
    localparam logic signed [INT_BITS-1:0] QUARTER_TURN = 32'sh4000_0000;
    localparam logic signed [ANGLE_BITS-1:0] UP_LIMIT = ANGLE_BITS'(1 << (ANGLE_BITS - 2));

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SITE_LATITUDE  = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SITE_LONGITUDE = 4'd1;

    localparam logic [ANGLE_BITS-1:0] LATITUDE_RESET  = 24'hEDB05B;
    localparam logic [ANGLE_BITS-1:0] LONGITUDE_RESET = 24'h140BD5;

    // Cycles from an accepted start to the result strobe.
    localparam int LATENCY = 3 * (CORDIC_STEPS + 1) + 4;

    typedef struct packed {
        logic                          cmd;
        logic [ANGLE_BITS-1:0]         sidereal_angle;
        logic [ANGLE_BITS-1:0]         angle_around;
        logic signed [ANGLE_BITS-1:0]  angle_up;
    } item_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]         result_around;
        logic signed [ANGLE_BITS-1:0]  result_up;
    } result_t;

    // Sideband that rides along the pipeline with each beat.
    typedef struct packed {
        logic                  cmd;
        logic [ANGLE_BITS-1:0] sid;
    } sc_tag_t;

    typedef struct packed {
        logic                  cmd;
        logic [ANGLE_BITS-1:0] sid;
        logic signed [DW-1:0]  zen;
    } v1_tag_t;

    typedef struct packed {
        logic                  cmd;
        logic [ANGLE_BITS-1:0] sid;
        logic [INT_BITS-1:0]   ra;
    } v2_tag_t;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic [INT_BITS-1:0] atan_turn(input int i);
        logic [INT_BITS-1:0] r;
        case (i)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            24: r = 32'h00000029;
            25: r = 32'h00000014;
            26: r = 32'h0000000A;
            27: r = 32'h00000005;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // Q30 product, rounded to nearest with ties toward plus infinity.
    function automatic logic signed [DW-1:0] qmul(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        logic signed [2*DW-1:0] p;
        p = a * b;
        p = p + (2*DW)'(64'sd536870912);
        return DW'(p >>> 30);
    endfunction

    // Round a 32-bit angle to ANGLE_BITS, half up, modulo one turn.
    function automatic logic [ANGLE_BITS-1:0] narrow(input logic [INT_BITS-1:0] a);
        logic [INT_BITS:0] s;
        s = {1'b0, a} + ((INT_BITS + 1)'(1) << (ANGLE_SHIFT - 1));
        return s[INT_BITS-1:ANGLE_SHIFT];
    endfunction

endpackage

// ===== sv/eht_sincos.sv =====
// Three-lane pipelined rotation-mode CORDIC: sine and cosine of three angles.
// One fold stage and one register stage per iteration. Depends on eht_pkg.
module eht_sincos
    import eht_pkg::*;
#(
    parameter int TAG_W = 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [TAG_W-1:0]           in_tag,
    input  logic [INT_BITS-1:0]        angle [3],
    output logic                       out_valid,
    output logic [TAG_W-1:0]           out_tag,
    output logic signed [DW-1:0]       cos_out [3],
    output logic signed [DW-1:0]       sin_out [3]
);

    logic                          valid_reg [CORDIC_STEPS+1];
    logic [TAG_W-1:0]              tag_reg   [CORDIC_STEPS+1];
    logic signed [DW-1:0]          x_reg     [CORDIC_STEPS+1][3];
    logic signed [DW-1:0]          y_reg     [CORDIC_STEPS+1][3];
    logic signed [INT_BITS-1:0]    t_reg     [CORDIC_STEPS+1][3];
    logic                          flip_reg  [CORDIC_STEPS+1][3];

    // Fold stage: bring each angle into a half turn round zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= in_tag;
        for (int l = 0; l < 3; l++)
        begin
            x_reg[0][l] <= KINV;
            y_reg[0][l] <= '0;
            if ($signed(angle[l]) > QUARTER_TURN || $signed(angle[l]) < -QUARTER_TURN)
            begin
                t_reg[0][l]    <= $signed(angle[l] + HALF_TURN);
                flip_reg[0][l] <= 1'b1;
            end
            else
            begin
                t_reg[0][l]    <= $signed(angle[l]);
                flip_reg[0][l] <= 1'b0;
            end
        end
    end

    // One micro-rotation per stage.
    for (genvar k = 1; k <= CORDIC_STEPS; k++)
    begin : g_step
        localparam logic [INT_BITS-1:0] ATAN = atan_turn(k - 1);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[k] <= tag_reg[k-1];
            for (int l = 0; l < 3; l++)
            begin
                flip_reg[k][l] <= flip_reg[k-1][l];
                if (t_reg[k-1][l] >= 0)
                begin
                    x_reg[k][l] <= x_reg[k-1][l] - (y_reg[k-1][l] >>> (k - 1));
                    y_reg[k][l] <= y_reg[k-1][l] + (x_reg[k-1][l] >>> (k - 1));
                    t_reg[k][l] <= t_reg[k-1][l] - $signed(ATAN);
                end
                else
                begin
                    x_reg[k][l] <= x_reg[k-1][l] + (y_reg[k-1][l] >>> (k - 1));
                    y_reg[k][l] <= y_reg[k-1][l] - (x_reg[k-1][l] >>> (k - 1));
                    t_reg[k][l] <= t_reg[k-1][l] + $signed(ATAN);
                end
            end
        end
    end

    // Undo the fold by negating both components.
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            cos_out[l] = flip_reg[CORDIC_STEPS][l] ? -x_reg[CORDIC_STEPS][l]
                                                   : x_reg[CORDIC_STEPS][l];
            sin_out[l] = flip_reg[CORDIC_STEPS][l] ? -y_reg[CORDIC_STEPS][l]
                                                   : y_reg[CORDIC_STEPS][l];
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS];
    assign out_tag   = tag_reg[CORDIC_STEPS];

endmodule

// ===== sv/eht_vector.sv =====
// Pipelined vectoring-mode CORDIC: angle and scaled length of a 2D vector.
// One fold stage and one register stage per iteration. Depends on eht_pkg.
module eht_vector
    import eht_pkg::*;
#(
    parameter int TAG_W = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [TAG_W-1:0]      in_tag,
    input  logic signed [DW-1:0]  vec_x,
    input  logic signed [DW-1:0]  vec_y,
    output logic                  out_valid,
    output logic [TAG_W-1:0]      out_tag,
    output logic [INT_BITS-1:0]   angle,
    output logic signed [DW-1:0]  length
);

    logic                       valid_reg [CORDIC_STEPS+1];
    logic [TAG_W-1:0]           tag_reg   [CORDIC_STEPS+1];
    logic signed [DW-1:0]       x_reg     [CORDIC_STEPS+1];
    logic signed [DW-1:0]       y_reg     [CORDIC_STEPS+1];
    logic [INT_BITS-1:0]        z_reg     [CORDIC_STEPS+1];
    logic                       zero_reg  [CORDIC_STEPS+1];

    // Fold stage: mirror into the right half plane, flag the null vector.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0]  <= in_tag;
        zero_reg[0] <= (vec_x == 0) && (vec_y == 0);
        if (vec_x < 0)
        begin
            x_reg[0] <= -vec_x;
            y_reg[0] <= -vec_y;
            z_reg[0] <= HALF_TURN;
        end
        else
        begin
            x_reg[0] <= vec_x;
            y_reg[0] <= vec_y;
            z_reg[0] <= '0;
        end
    end

    // One micro-rotation per stage, driving y toward zero.
    for (genvar k = 1; k <= CORDIC_STEPS; k++)
    begin : g_step
        localparam logic [INT_BITS-1:0] ATAN = atan_turn(k - 1);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[k]  <= tag_reg[k-1];
            zero_reg[k] <= zero_reg[k-1];
            if (y_reg[k-1] >= 0)
            begin
                x_reg[k] <= x_reg[k-1] + (y_reg[k-1] >>> (k - 1));
                y_reg[k] <= y_reg[k-1] - (x_reg[k-1] >>> (k - 1));
                z_reg[k] <= z_reg[k-1] + ATAN;
            end
            else
            begin
                x_reg[k] <= x_reg[k-1] - (y_reg[k-1] >>> (k - 1));
                y_reg[k] <= y_reg[k-1] + (x_reg[k-1] >>> (k - 1));
                z_reg[k] <= z_reg[k-1] - ATAN;
            end
        end
    end

    // The null vector has angle zero; its length is already zero.
    assign angle     = zero_reg[CORDIC_STEPS] ? '0 : z_reg[CORDIC_STEPS];
    assign length    = x_reg[CORDIC_STEPS];
    assign out_valid = valid_reg[CORDIC_STEPS];
    assign out_tag   = tag_reg[CORDIC_STEPS];

endmodule

// ===== sv/equatorial_horizontal_transform.sv =====
// Throughput: one item per cycle; busy stays low, start may be held every cycle.
// The depth is set by three 31-stage CORDIC pipelines plus four product/output stages.
// Reset clears all valid bits and loads the site registers with their defaults.
// Results are strobed for one cycle on result_valid; the receiver cannot stall.
module equatorial_horizontal_transform
    import eht_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  item_t                      item,
    output logic                       result_valid,
    output result_t                    result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ANGLE_BITS-1:0]      cfg_data
);

    localparam int SC_TAG_W = $bits(sc_tag_t);
    localparam int V1_TAG_W = $bits(v1_tag_t);
    localparam int V2_TAG_W = $bits(v2_tag_t);

    logic [ANGLE_BITS-1:0] latitude_reg;
    logic [ANGLE_BITS-1:0] longitude_reg;

    // Site registers; the port never pushes back.
    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latitude_reg  <= LATITUDE_RESET;
            longitude_reg <= LONGITUDE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SITE_LATITUDE:  latitude_reg  <= cfg_data;
                REG_SITE_LONGITUDE: longitude_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Input angles: hour angle or azimuth, elevation, site latitude.
    logic                  accept;
    logic [ANGLE_BITS-1:0] hour_angle;
    logic [INT_BITS-1:0]   sc_angle [3];
    sc_tag_t               sc_tag_in;

    assign accept     = start && !busy;
    assign hour_angle = item.sidereal_angle - item.angle_around + longitude_reg;

    always_comb
    begin
        sc_angle[0] = {(item.cmd ? item.angle_around : hour_angle), {ANGLE_SHIFT{1'b0}}};
        sc_angle[1] = {item.angle_up, {ANGLE_SHIFT{1'b0}}};
        sc_angle[2] = {latitude_reg, {ANGLE_SHIFT{1'b0}}};
        sc_tag_in.cmd = item.cmd;
        sc_tag_in.sid = item.sidereal_angle;
    end

    logic                  sc_valid;
    logic [SC_TAG_W-1:0]   sc_tag_bits;
    logic signed [DW-1:0]  sc_cos [3];
    logic signed [DW-1:0]  sc_sin [3];

    eht_sincos #(
        .TAG_W (SC_TAG_W)
    ) u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_tag    (sc_tag_in),
        .angle     (sc_angle),
        .out_valid (sc_valid),
        .out_tag   (sc_tag_bits),
        .cos_out   (sc_cos),
        .sin_out   (sc_sin)
    );

    // First product stage.
    logic                  m1_valid_reg;
    sc_tag_t               m1_tag_reg;
    logic signed [DW-1:0]  cacu_reg;
    logic signed [DW-1:0]  east_reg;
    logic signed [DW-1:0]  cl_su_reg;
    logic signed [DW-1:0]  sl_su_reg;
    logic signed [DW-1:0]  cl_reg;
    logic signed [DW-1:0]  sl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else
        begin
            m1_valid_reg <= sc_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_tag_reg <= sc_tag_t'(sc_tag_bits);
        cacu_reg   <= qmul(sc_cos[0], sc_cos[1]);
        east_reg   <= -qmul(sc_sin[0], sc_cos[1]);
        cl_su_reg  <= qmul(sc_cos[2], sc_sin[1]);
        sl_su_reg  <= qmul(sc_sin[2], sc_sin[1]);
        cl_reg     <= sc_cos[2];
        sl_reg     <= sc_sin[2];
    end

    // Second product stage: north and zenith components.
    logic                  m2_valid_reg;
    v1_tag_t               m2_tag_reg;
    logic signed [DW-1:0]  north_reg;
    logic signed [DW-1:0]  m2_east_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_valid_reg <= 1'b0;
        end
        else
        begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m2_tag_reg.cmd <= m1_tag_reg.cmd;
        m2_tag_reg.sid <= m1_tag_reg.sid;
        m2_tag_reg.zen <= sl_su_reg + qmul(cacu_reg, cl_reg);
        north_reg      <= cl_su_reg - qmul(cacu_reg, sl_reg);
        m2_east_reg    <= east_reg;
    end

    // Around angle from the horizontal vector.
    logic                  v1_valid;
    logic [V1_TAG_W-1:0]   v1_tag_bits;
    v1_tag_t               v1_tag;
    logic [INT_BITS-1:0]   v1_angle;
    logic signed [DW-1:0]  v1_length;

    eht_vector #(
        .TAG_W (V1_TAG_W)
    ) u_vector_around (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m2_valid_reg),
        .in_tag    (m2_tag_reg),
        .vec_x     (north_reg),
        .vec_y     (m2_east_reg),
        .out_valid (v1_valid),
        .out_tag   (v1_tag_bits),
        .angle     (v1_angle),
        .length    (v1_length)
    );

    assign v1_tag = v1_tag_t'(v1_tag_bits);

    // Scale the CORDIC length back to a unit magnitude.
    logic                  m3_valid_reg;
    v2_tag_t               m3_tag_reg;
    logic signed [DW-1:0]  mag_reg;
    logic signed [DW-1:0]  m3_zen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m3_valid_reg <= 1'b0;
        end
        else
        begin
            m3_valid_reg <= v1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        m3_tag_reg.cmd <= v1_tag.cmd;
        m3_tag_reg.sid <= v1_tag.sid;
        m3_tag_reg.ra  <= v1_angle;
        mag_reg        <= qmul(v1_length, KINV);
        m3_zen_reg     <= v1_tag.zen;
    end

    // Up angle from (horizontal magnitude, zenith).
    logic                  v2_valid;
    logic [V2_TAG_W-1:0]   v2_tag_bits;
    v2_tag_t               v2_tag;
    logic [INT_BITS-1:0]   v2_angle;
    logic signed [DW-1:0]  v2_length;

    eht_vector #(
        .TAG_W (V2_TAG_W)
    ) u_vector_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m3_valid_reg),
        .in_tag    (m3_tag_reg),
        .vec_x     (mag_reg),
        .vec_y     (m3_zen_reg),
        .out_valid (v2_valid),
        .out_tag   (v2_tag_bits),
        .angle     (v2_angle),
        .length    (v2_length)
    );

    assign v2_tag = v2_tag_t'(v2_tag_bits);

    // Output stage: rounding, sidereal correction and clamping of the up angle.
    logic                          out_valid_reg;
    result_t                       result_reg;
    logic [ANGLE_BITS-1:0]         around_narrow;
    logic signed [ANGLE_BITS-1:0]  up_narrow;
    logic signed [ANGLE_BITS-1:0]  up_clamped;
    logic                          length_sign;

    assign around_narrow = narrow(v2_tag.ra);
    assign up_narrow     = $signed(narrow(v2_angle));
    // The final length is never negative; keep its sign as a zero-cost sanity tap.
    assign length_sign   = v2_length[DW-1];

    always_comb
    begin
        if (up_narrow > UP_LIMIT)
        begin
            up_clamped = UP_LIMIT;
        end
        else if (up_narrow < -UP_LIMIT)
        begin
            up_clamped = -UP_LIMIT;
        end
        else
        begin
            up_clamped = up_narrow;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= v2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_tag.cmd)
        begin
            result_reg.result_around <= v2_tag.sid - around_narrow + longitude_reg;
        end
        else
        begin
            result_reg.result_around <= around_narrow;
        end
        result_reg.result_up <= up_clamped;
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // Every strobe traces back to a start exactly one pipeline depth earlier.
    a_strobe_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching start");

    // The up result stays within a quarter turn.
    a_up_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.result_up <= UP_LIMIT && result.result_up >= -UP_LIMIT))
        else $error("result_up outside a quarter turn");

    // The second vectoring stage sees a non-negative x, so its length is never negative.
    a_length_sign: assert property (@(posedge clk) disable iff (!rst_n)
        v2_valid |-> !length_sign)
        else $error("negative magnitude out of the up-angle CORDIC");

endmodule
